// ===== rtl/xrng_pkg.sv =====
// xrng_pkg: shared types, constants and functions for the xoshiro256** block.
// Depends on nothing; used by xrng_front, xrng_back and the top level under rtl.
package xrng_pkg;

   typedef enum logic [2:0] {
      OP_SEED   = 3'd0,
      OP_WORD64 = 3'd1,
      OP_UPPER  = 3'd2,
      OP_BOOL   = 3'd3,
      OP_RANGE  = 3'd4,
      OP_FRAC   = 3'd5,
      OP_RSVD6  = 3'd6,
      OP_RSVD7  = 3'd7
   } opcode_type;

   localparam logic [63:0] GOLDEN_INC = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] MIX_MUL_A  = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] MIX_MUL_B  = 64'h94D049BB133111EB;

   // reset state: SplitMix64 expansion of seed zero
   localparam logic [63:0] RESET_S0 = 64'hE220A8397B1DCDAF;
   localparam logic [63:0] RESET_S1 = 64'h6E789E6AA1B965F4;
   localparam logic [63:0] RESET_S2 = 64'h06C45D188009454F;
   localparam logic [63:0] RESET_S3 = 64'hF88BB8A8724C81EC;

   // classified command passed from the front end to the back end
   typedef struct packed {
      opcode_type  op;
      logic        degen;
      logic [63:0] seed;
      logic [31:0] lo;
      logic [32:0] span;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED_ADD,
      ST_SEED_M1,
      ST_SEED_M2,
      ST_SEED_FIN,
      ST_REM,
      ST_DRAW,
      ST_CHECK,
      ST_MOD,
      ST_DONE
   } state_type;

   function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned n);
      rotl = (x << n) | (x >> (64 - n));
   endfunction

endpackage

// ===== rtl/xrng_mul64.sv =====
// xrng_mul64: 64x64 low-half multiplier built from 32x32 partial products.
// Depends on nothing; used by xrng_back.
module xrng_mul64 (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic        done,
   output logic [63:0] product
);
   logic [2:0]  step_ff, step_in;
   logic [63:0] a_ff, b_ff, acc_ff, acc_in;
   logic [31:0] pa, pb;
   logic [63:0] pp_ff;
   logic        load;

   // a new operation may start when idle or in the cycle that the last one finishes
   assign load = start && (step_ff == 3'd0 || step_ff == 3'd4);

   always_comb begin
      pa = a_ff[31:0];
      pb = b_ff[31:0];
      unique case (step_ff)
         3'd1:    begin pa = a_ff[31:0];  pb = b_ff[31:0];  end
         3'd2:    begin pa = a_ff[31:0];  pb = b_ff[63:32]; end
         3'd3:    begin pa = a_ff[63:32]; pb = b_ff[31:0];  end
         default: begin pa = a_ff[31:0];  pb = b_ff[31:0];  end
      endcase
   end

   always_comb begin
      acc_in = acc_ff;
      unique case (step_ff)
         3'd2:    acc_in = pp_ff;
         3'd3:    acc_in = acc_ff + {pp_ff[31:0], 32'd0};
         3'd4:    acc_in = acc_ff + {pp_ff[31:0], 32'd0};
         default: acc_in = acc_ff;
      endcase
      step_in = (step_ff == 3'd0 || step_ff == 3'd4) ? (start ? 3'd1 : 3'd0)
              : step_ff + 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 3'd0;
      end else begin
         step_ff <= step_in;
      end
      if (load) begin
         a_ff <= a;
         b_ff <= b;
      end
      pp_ff  <= {32'd0, pa} * {32'd0, pb};
      acc_ff <= acc_in;
   end

   // the last partial product is added on the way out
   assign done    = (step_ff == 3'd4);
   assign product = acc_in;
endmodule

// ===== rtl/xrng_divmod.sv =====
// xrng_divmod: restoring remainder of a 64-bit dividend by a 33-bit divisor,
// one quotient bit a cycle. Depends on nothing.
module xrng_divmod (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [32:0] divisor,
   output logic        done,
   output logic [32:0] remainder
);
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] num_ff, num_in;
   logic [33:0] rem_ff, rem_in, trial;
   logic [32:0] div_ff;
   logic        busy_ff, busy_in;

   always_comb begin
      trial   = {rem_ff[32:0], num_ff[63]} - {1'b0, div_ff};
      num_in  = num_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            num_in  = dividend;
            rem_in  = 34'd0;
            cnt_in  = 7'd0;
         end
      end else begin
         num_in = {num_ff[62:0], 1'b0};
         rem_in = trial[33] ? {rem_ff[32:0], num_ff[63]} : trial;
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 7'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      if (start && !busy_ff) div_ff <= divisor;
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign done      = busy_ff && (cnt_ff == 7'd63);
   assign remainder = rem_in[32:0];
endmodule

// ===== rtl/xrng_front.sv =====
// xrng_front: accepts request transfers, classifies them and queues commands.
// Depends on xrng_pkg.
module xrng_front #(
   parameter int DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [135:0]       req_tdata,
   output logic               cmd_valid,
   input  logic               cmd_take,
   output xrng_pkg::cmd_type  cmd
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   xrng_pkg::cmd_type q_ff [DEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0]   cnt_ff;
   xrng_pkg::cmd_type c;
   logic          push, pop;
   logic signed [32:0] lo_s, hi_s;

   always_comb begin
      c.op    = xrng_pkg::opcode_type'(req_tdata[2:0]);
      c.seed  = req_tdata[66:3];
      c.lo    = req_tdata[98:67];
      lo_s    = {req_tdata[98], req_tdata[98:67]};
      hi_s    = {req_tdata[130], req_tdata[130:99]};
      c.degen = (lo_s >= hi_s);
      c.span  = 33'(hi_s - lo_s);
   end

   assign req_tready = (cnt_ff != (AW+1)'(DEPTH));
   // drop reserved opcodes at the door
   assign push = req_tvalid && req_tready &&
                 c.op != xrng_pkg::OP_RSVD6 && c.op != xrng_pkg::OP_RSVD7;
   assign pop  = cmd_take && cmd_valid;
   assign cmd_valid = (cnt_ff != '0);
   assign cmd = q_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + AW'(1);
         if (pop)  rp_ff <= (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + AW'(1);
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
      if (push) q_ff[wp_ff] <= c;
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(DEPTH)) else $error("queue count over depth");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != '0) else $error("pop from empty queue");
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == (AW+1)'(DEPTH) |-> !req_tready) else $error("ready while full");
endmodule

// ===== rtl/xrng_back.sv =====
// xrng_back: executes queued commands: seeding, draws, rejection and reduction.
// Depends on xrng_pkg, xrng_mul64 and xrng_divmod.
module xrng_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   output logic               cmd_take,
   input  xrng_pkg::cmd_type  cmd,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [103:0]       rsp_tdata
);
   xrng_pkg::state_type st_ff, st_in;
   logic [63:0] s0_ff, s1_ff, s2_ff, s3_ff;
   logic [63:0] acc_ff, z_ff, w_ff, lim_ff;
   logic [32:0] rem_ff;
   logic [1:0]  k_ff;
   xrng_pkg::cmd_type c_ff;
   logic [63:0] word_ff;
   logic [31:0] rng_ff;
   logic [2:0]  kind_ff;
   logic        out_v_ff;

   logic        mul_start, mul_done, dv_start, dv_done;
   logic [63:0] mul_a, mul_b, mul_p, dv_num, outw, rot1, acc_nx;
   logic [32:0] dv_rem;
   logic        rem_mode_ff;

   xrng_mul64 u_mul (.clock, .reset, .start(mul_start), .a(mul_a), .b(mul_b),
                     .done(mul_done), .product(mul_p));
   xrng_divmod u_div (.clock, .reset, .start(dv_start), .dividend(dv_num),
                      .divisor(c_ff.span), .done(dv_done), .remainder(dv_rem));

   assign rot1 = xrng_pkg::rotl(s1_ff * 64'd5, 7);
   assign outw = rot1 + {rot1[60:0], 3'd0};
   // advance the SplitMix64 counter before mixing; chain the second multiply
   // straight off the first product
   assign acc_nx = acc_ff + xrng_pkg::GOLDEN_INC;
   assign mul_a = (st_ff == xrng_pkg::ST_SEED_ADD) ? (acc_nx ^ (acc_nx >> 30))
                                                   : (mul_p ^ (mul_p >> 27));
   assign mul_b = (st_ff == xrng_pkg::ST_SEED_ADD) ? xrng_pkg::MIX_MUL_A
                                                   : xrng_pkg::MIX_MUL_B;
   assign dv_num = (st_ff == xrng_pkg::ST_REM) ? (64'd0 - {31'd0, c_ff.span}) : w_ff;
   assign cmd_take = (st_ff == xrng_pkg::ST_IDLE) && !out_v_ff;

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         xrng_pkg::ST_IDLE:
            if (cmd_valid && !out_v_ff) begin
               if (cmd.op == xrng_pkg::OP_SEED) st_in = xrng_pkg::ST_SEED_ADD;
               else if (cmd.op == xrng_pkg::OP_RANGE && !cmd.degen)
                  st_in = xrng_pkg::ST_REM;
               else if (cmd.op == xrng_pkg::OP_RANGE) st_in = xrng_pkg::ST_DONE;
               else st_in = xrng_pkg::ST_DRAW;
            end
         xrng_pkg::ST_SEED_ADD: st_in = xrng_pkg::ST_SEED_M1;
         xrng_pkg::ST_SEED_M1:  if (mul_done) st_in = xrng_pkg::ST_SEED_M2;
         xrng_pkg::ST_SEED_M2:  if (mul_done) st_in = xrng_pkg::ST_SEED_FIN;
         xrng_pkg::ST_SEED_FIN:
            st_in = (k_ff == 2'd3) ? xrng_pkg::ST_IDLE : xrng_pkg::ST_SEED_ADD;
         xrng_pkg::ST_REM:      if (dv_done) st_in = xrng_pkg::ST_DRAW;
         xrng_pkg::ST_DRAW:
            st_in = (c_ff.op == xrng_pkg::OP_RANGE) ? xrng_pkg::ST_CHECK
                                                   : xrng_pkg::ST_DONE;
         xrng_pkg::ST_CHECK:
            st_in = (rem_ff != 33'd0 && w_ff >= lim_ff) ? xrng_pkg::ST_DRAW
                                                       : xrng_pkg::ST_MOD;
         xrng_pkg::ST_MOD:      if (dv_done) st_in = xrng_pkg::ST_DONE;
         xrng_pkg::ST_DONE:     st_in = xrng_pkg::ST_IDLE;
         default:               st_in = xrng_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      mul_start = 1'b0;
      dv_start  = 1'b0;
      unique case (st_ff)
         xrng_pkg::ST_SEED_ADD: mul_start = 1'b1;
         xrng_pkg::ST_SEED_M1:  mul_start = mul_done;
         xrng_pkg::ST_REM:      dv_start  = !rem_mode_ff;
         xrng_pkg::ST_CHECK:    dv_start  = !(rem_ff != 33'd0 && w_ff >= lim_ff);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= xrng_pkg::ST_IDLE;
         out_v_ff <= 1'b0;
         s0_ff <= xrng_pkg::RESET_S0;
         s1_ff <= xrng_pkg::RESET_S1;
         s2_ff <= xrng_pkg::RESET_S2;
         s3_ff <= xrng_pkg::RESET_S3;
         rem_mode_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (rsp_tvalid && rsp_tready) out_v_ff <= 1'b0;
         if (st_ff == xrng_pkg::ST_IDLE && cmd_valid && !out_v_ff) begin
            c_ff   <= cmd;
            acc_ff <= cmd.seed;
            k_ff   <= 2'd0;
         end
         if (st_ff == xrng_pkg::ST_SEED_ADD) acc_ff <= acc_nx;
         if (st_ff == xrng_pkg::ST_SEED_M1 && mul_done) z_ff <= mul_p;
         if (st_ff == xrng_pkg::ST_SEED_M2 && mul_done) z_ff <= mul_p;
         if (st_ff == xrng_pkg::ST_SEED_FIN) begin
            // shift the new word in at the top; four steps fill s0..s3
            s0_ff <= s1_ff;
            s1_ff <= s2_ff;
            s2_ff <= s3_ff;
            s3_ff <= z_ff ^ (z_ff >> 31);
            k_ff  <= k_ff + 2'd1;
         end
         if (st_ff == xrng_pkg::ST_REM) begin
            rem_mode_ff <= !dv_done;
            if (dv_done) begin
               rem_ff <= dv_rem;
               lim_ff <= 64'd0 - {31'd0, dv_rem};
            end
         end
         if (st_ff == xrng_pkg::ST_DRAW) begin
            w_ff  <= outw;
            s2_ff <= s2_ff ^ s0_ff ^ (s1_ff << 17);
            s3_ff <= xrng_pkg::rotl(s3_ff ^ s1_ff, 45);
            s1_ff <= s1_ff ^ s2_ff ^ s0_ff;
            s0_ff <= s0_ff ^ s3_ff ^ s1_ff;
         end
         if (st_ff == xrng_pkg::ST_DONE) begin
            out_v_ff <= 1'b1;
            kind_ff  <= c_ff.op;
            unique case (c_ff.op)
               xrng_pkg::OP_WORD64: begin word_ff <= w_ff;       rng_ff <= 32'd0; end
               xrng_pkg::OP_UPPER:  begin word_ff <= w_ff >> 32; rng_ff <= 32'd0; end
               xrng_pkg::OP_BOOL:   begin word_ff <= w_ff >> 63; rng_ff <= 32'd0; end
               xrng_pkg::OP_FRAC:   begin word_ff <= w_ff >> 11; rng_ff <= 32'd0; end
               xrng_pkg::OP_RANGE: begin
                  word_ff <= 64'd0;
                  rng_ff  <= c_ff.degen ? c_ff.lo : c_ff.lo + rem_ff[31:0];
               end
               default: begin word_ff <= 64'd0; rng_ff <= 32'd0; end
            endcase
         end
         if (st_ff == xrng_pkg::ST_MOD && dv_done) rem_ff <= dv_rem;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {5'd0, kind_ff, rng_ff, word_ff};

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("result dropped");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> st_ff == xrng_pkg::ST_IDLE && !out_v_ff) else $error("bad take");
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> kind_ff != xrng_pkg::OP_SEED) else $error("seed gave result");
endmodule

// ===== rtl/xoshiro256ss_prng_with_range.sv =====
// xoshiro256ss_prng_with_range: top level of the xoshiro256** generator.
// Depends on xrng_pkg, xrng_front and xrng_back.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | opcode, seed_value, range_begin, range_end
//  rsp     | out | rsp_tvalid/tready    | word_value, ranged_value, result_kind
//
// Sequence: a plain draw is taken from the queue, drawn, formatted into the
// result register, and the result transferred before the next command is taken.
// Seeding takes the command, then runs four SplitMix64 steps, each using the
// shared 64-bit multiplier twice. A ranged draw first finds 2^64 mod span, then
// draws words until one passes rejection, then reduces it, both remainders coming
// from the one-bit-a-cycle remainder unit.
// Reset loads the seed-zero state at once. The front queue keeps taking
// requests while the back end works or a result waits on rsp_tready, until
// its QUEUE_DEPTH entries are full.
module xoshiro256ss_prng_with_range #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [2:0] opcode, [66:3] seed_value, [98:67] range_begin, [130:99] range_end
   input  logic [135:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [63:0] word_value, [95:64] ranged_value, [98:96] result_kind
   output logic [103:0] rsp_tdata
);
   logic              cmd_valid, cmd_take;
   xrng_pkg::cmd_type cmd;

   // front: accept and classify, queue for the back end
   xrng_front #(.DEPTH(QUEUE_DEPTH)) u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .cmd_valid, .cmd_take, .cmd
   );

   // back: advance state, reject, reduce, hold result
   xrng_back u_back (
      .clock, .reset, .cmd_valid, .cmd_take, .cmd,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );
endmodule

// ===== verif/xrng_checker.sv =====
// xrng_checker: watches the request and result channels of the xoshiro256** block,
// predicts each result from its own copy of the generator state and compares.
// Depends on xrng_pkg for the opcode enum and the SplitMix64 constants.
`timescale 1ns / 100ps
module xrng_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [135:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [103:0] rsp_tdata,
   output int           fail_count,
   output int           pending_count
);

   // laid out as on rsp_tdata, lowest field last
   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] ranged;
      logic [63:0] word;
   } draw_result_type;

   logic [63:0]     gen_words [4];
   draw_result_type pending_draws [$];

   assign pending_count = pending_draws.size();

   function automatic logic [63:0] splitmix_next(ref logic [63:0] acc);
      logic [63:0] z;
      acc = acc + xrng_pkg::GOLDEN_INC;
      z = acc;
      z = (z ^ (z >> 30)) * xrng_pkg::MIX_MUL_A;
      z = (z ^ (z >> 27)) * xrng_pkg::MIX_MUL_B;
      return z ^ (z >> 31);
   endfunction

   task automatic seed_words(input logic [63:0] seed);
      logic [63:0] acc;
      acc = seed;
      for (int k = 0; k < 4; k++) gen_words[k] = splitmix_next(acc);
   endtask

   function automatic logic [63:0] rol64(input logic [63:0] x, input int n);
      return (x << n) | (x >> (64 - n));
   endfunction

   task automatic draw_next(output logic [63:0] w);
      logic [63:0] sh;
      w  = rol64(gen_words[1] * 64'd5, 7) * 64'd9;
      sh = gen_words[1] << 17;
      gen_words[2] ^= gen_words[0];
      gen_words[3] ^= gen_words[1];
      gen_words[1] ^= gen_words[2];
      gen_words[0] ^= gen_words[3];
      gen_words[2] ^= sh;
      gen_words[3] = rol64(gen_words[3], 45);
   endtask

   // advance the generator for one request; push a result unless it gives none
   task automatic predict_request(input logic [135:0] d);
      xrng_pkg::opcode_type op;
      logic [63:0]   w, span, rem, lim;
      logic signed [31:0] lo, hi;
      draw_result_type r;
      op = xrng_pkg::opcode_type'(d[2:0]);
      lo = d[98:67];
      hi = d[130:99];
      r = '0;
      r.kind = op;
      case (op)
         xrng_pkg::OP_SEED: begin
            seed_words(d[66:3]);
            return;
         end
         xrng_pkg::OP_WORD64: begin draw_next(w); r.word = w; end
         xrng_pkg::OP_UPPER:  begin draw_next(w); r.word = w >> 32; end
         xrng_pkg::OP_BOOL:   begin draw_next(w); r.word = w >> 63; end
         xrng_pkg::OP_FRAC:   begin draw_next(w); r.word = w >> 11; end
         xrng_pkg::OP_RANGE: begin
            if (lo >= hi) begin
               r.ranged = lo;
            end else begin
               span = 64'(64'(signed'(hi)) - 64'(signed'(lo)));
               rem = (64'd0 - span) % span;
               lim = 64'd0 - rem;
               do draw_next(w); while (rem != 0 && w >= lim);
               r.ranged = 32'(lo) + 32'(w % span);
            end
         end
         default: return;
      endcase
      pending_draws.push_back(r);
   endtask

   always @(posedge clock) begin
      draw_result_type got, want;
      if (reset) begin
         seed_words(64'd0);
         pending_draws.delete();
         fail_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[98:0];
            if (pending_draws.size() == 0) begin
               $display("%0t: unexpected result %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = pending_draws.pop_front();
               if (got.word !== want.word || got.ranged !== want.ranged
                   || got.kind !== want.kind) begin
                  $display("%0t: mismatch expected %h actual %h", $time, want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
         // predict after popping so a same-edge request cannot be compared early
         if (req_tvalid && req_tready) predict_request(req_tdata);
      end
   end

endmodule

// ===== verif/xoshiro256ss_prng_with_range_test.sv =====
// xoshiro256ss_prng_with_range_test: drives seeds, draws and ranged draws into
// the generator with random gaps and stalls; xrng_checker gives the verdict data.
// Depends on xrng_pkg, xrng_checker and the RTL top level.
`timescale 1ns / 100ps
module xoshiro256ss_prng_with_range_test;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [103:0] rsp_tdata;
   int           fail_count, pending_count;
   int           idle_cycles = 0;
   bit           hold_off = 0;
   bit           stim_done = 0;

   localparam int IDLE_LIMIT = 20000;

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   xoshiro256ss_prng_with_range dut (.*);

   xrng_checker checker_i (.*);

   // short gaps mostly, now and then a long one
   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 40) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [135:0] pack_req(input xrng_pkg::opcode_type op,
                                             input logic [63:0] seed,
                                             input logic [31:0] lo, input logic [31:0] hi);
      return {5'd0, hi, lo, seed, 3'(op)};
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // random request: mostly draws, some seeds, ranged bounds of varied spans
   function automatic logic [135:0] random_req();
      int p;
      logic [31:0] lo, hi;
      xrng_pkg::opcode_type op;
      p = $urandom_range(0, 99);
      lo = $urandom;
      hi = $urandom;
      if (p < 8) op = xrng_pkg::OP_SEED;
      else if (p < 18) op = xrng_pkg::OP_WORD64;
      else if (p < 28) op = xrng_pkg::OP_UPPER;
      else if (p < 38) op = xrng_pkg::OP_BOOL;
      else if (p < 48) op = xrng_pkg::OP_FRAC;
      else if (p < 95) op = xrng_pkg::OP_RANGE;
      else op = xrng_pkg::opcode_type'($urandom_range(6, 7));
      if (op == xrng_pkg::OP_RANGE && $urandom_range(0, 2) != 0) begin
         // small spans, including powers of two, above a random begin
         hi = lo + ($urandom_range(0, 1) ? (32'd1 << $urandom_range(0, 8))
                                        : $urandom_range(1, 1000));
         if ($signed(hi) < $signed(lo)) hi = 32'h7FFFFFFF;
      end
      return pack_req(op, rand64(), lo, hi);
   endfunction

   // hold valid across back-to-back transfers; drop it only for a gap
   task automatic send(input logic [135:0] d);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // receiver: random stalls, plus one long hold-off while requests keep coming
   initial begin
      int g;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_tready <= 0;
            repeat (400) @(posedge clock);
            hold_off = 0;
         end
         g = gap_len();
         if (g > 0) begin
            rsp_tready <= 0;
            repeat (g) @(posedge clock);
         end
         rsp_tready <= 1;
      end
   end

   // watchdog: count cycles with no transfer on either channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: draw from reset state, each opcode, the special cases
      send(pack_req(xrng_pkg::OP_WORD64, '0, '0, '0));
      send(pack_req(xrng_pkg::OP_UPPER, '0, '0, '0));
      send(pack_req(xrng_pkg::OP_BOOL, '0, '0, '0));
      send(pack_req(xrng_pkg::OP_FRAC, '0, '0, '0));
      send(pack_req(xrng_pkg::OP_RANGE, '0, 32'd5, 32'd5));
      send(pack_req(xrng_pkg::OP_RANGE, '0, 32'd9, 32'd2));
      send(pack_req(xrng_pkg::OP_RANGE, '0, 32'h80000000, 32'h7FFFFFFF));
      send(pack_req(xrng_pkg::OP_RANGE, '0, 32'h7FFFFFFF, 32'h80000000));
      send(pack_req(xrng_pkg::OP_RANGE, '0, 32'd0, 32'd16));
      send(pack_req(xrng_pkg::OP_RANGE, '0, 32'hFFFFFFFF, 32'd0));
      send(pack_req(xrng_pkg::OP_RANGE, '0, 32'd0, 32'd3));
      send(pack_req(xrng_pkg::OP_RSVD6, '1, '1, '1));
      send(pack_req(xrng_pkg::OP_RSVD7, '0, '0, '0));
      send(pack_req(xrng_pkg::OP_SEED, '1, '1, '1));
      send(pack_req(xrng_pkg::OP_WORD64, '1, '1, '1));
      send(pack_req(xrng_pkg::OP_SEED, '0, '0, '0));
      send(pack_req(xrng_pkg::OP_WORD64, '0, '0, '0));
      send(pack_req(xrng_pkg::OP_SEED, 64'h0123456789ABCDEF, '0, '0));
      send(pack_req(xrng_pkg::OP_RANGE, '0, 32'hFFFFFF00, 32'd100));
      hold_off = 1;
      for (int k = 0; k < 12; k++) send(pack_req(xrng_pkg::OP_WORD64, '0, '0, '0));
      for (int k = 0; k < 550; k++) send(random_req());
      req_tvalid <= 0;
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      // let the checker see the last request transfer before draining
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
